// File: rtl/nnls_pkg.sv
// Shared types and constants of the nearest-neighbor line scaler.
// Used by nnls_luma, by the top level of the scaler and by its checker; depends on nothing.
`default_nettype none

package nnls_pkg;

    // Fixed field and register widths.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 16;
    localparam int COL_W     = 10;
    localparam int ROWS_W    = 7;
    localparam int DRB_W     = 12;
    localparam int LUMA_W    = 6;
    localparam int LUMA_SUM_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TEXT_MODE  = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] CFG_RST_SRC_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] CFG_RST_SRC_HEIGHT = 11'd240;
    localparam logic [CFG_W-1:0] CFG_RST_DST_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] CFG_RST_DST_HEIGHT = 11'd240;

    // Luma weights and the brightness threshold of the text rule.
    localparam logic [LUMA_W-1:0]     LUMA_RB_MASK = 6'h3E;
    localparam logic [LUMA_W-1:0]     LUMA_G_MASK  = 6'h3F;
    localparam logic [LUMA_SUM_W-1:0] LUMA_R_COEF  = 16'd218;
    localparam logic [LUMA_SUM_W-1:0] LUMA_G_COEF  = 16'd732;
    localparam logic [LUMA_SUM_W-1:0] LUMA_B_COEF  = 16'd74;
    localparam logic [LUMA_W-1:0]     LUMA_THRESH  = 6'd24;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic [COL_W-1:0]  dest_x;
        logic [COL_W-1:0]  first_dest_row;
        logic [ROWS_W-1:0] row_count;
        logic              run_last;
    } t_pix_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_VERT,
        S_HORIZ
    } t_state;

endpackage

`default_nettype wire

// File: rtl/nnls_err_unit.sv
// Shared error accumulator step of the scaler: adds the source dimension
// while the error is negative, otherwise subtracts the destination dimension.
// Depends on nothing.
`default_nettype none

module nnls_err_unit #(
    parameter int W = 12
) (
    input  wire logic signed [W-1:0] i_acc,
    input  wire logic signed [W-1:0] i_step,
    input  wire logic signed [W-1:0] i_back,
    output logic signed [W-1:0]      o_next,
    output logic                     o_done,
    output logic                     o_next_nonneg
);

    logic signed [W-1:0] addend;

    // A non-negative error means the run is complete.
    assign o_done        = ~i_acc[W-1];
    assign addend        = o_done ? -i_back : i_step;
    assign o_next        = i_acc + addend;
    assign o_next_nonneg = ~o_next[W-1];

endmodule

`default_nettype wire

// File: rtl/nnls_luma.sv
// Brightness test of an RGB565 pixel for the text sharpening rule.
// Depends on nnls_pkg for the luma weights and threshold.
`default_nettype none

module nnls_luma
    import nnls_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_pixel,
    output logic                  o_bright
);

    logic [LUMA_W-1:0]     r6;
    logic [LUMA_W-1:0]     g6;
    logic [LUMA_W-1:0]     b6;
    logic [LUMA_SUM_W-1:0] y_sum;
    logic [LUMA_W-1:0]     luma;

    // Red and blue are widened to six bits with a zero LSB.
    assign r6 = LUMA_W'(i_pixel >> 10) & LUMA_RB_MASK;
    assign g6 = LUMA_W'(i_pixel >> 5) & LUMA_G_MASK;
    assign b6 = LUMA_W'({i_pixel, 1'b0}) & LUMA_RB_MASK;

    assign y_sum = LUMA_SUM_W'(LUMA_SUM_W'(r6) * LUMA_R_COEF
                             + LUMA_SUM_W'(g6) * LUMA_G_COEF
                             + LUMA_SUM_W'(b6) * LUMA_B_COEF);

    // Round to six bits.
    assign luma     = LUMA_W'(y_sum >> 10) + LUMA_W'(y_sum[9]);
    assign o_bright = luma > LUMA_THRESH;

endmodule

`default_nettype wire

// File: rtl/nearest_neighbor_line_scaler.sv
// Top level of the nearest-neighbor RGB565 line scaler.
// Depends on nnls_pkg, nnls_err_unit and nnls_luma.
//
// Usage: source pixels enter in raster order on the input channel
// (i_in_valid, o_in_stall, i_in_data); frame_start on the first pixel of a
// frame restarts all counters. Each pixel produces zero to MAX_REPLICAS
// output transactions (o_out_valid, i_out_stall, o_out_data), one per
// destination copy, with run_last set on the last one and the first row and
// row count of the current source line on every copy. Configuration writes
// use i_cfg_valid / o_cfg_ready, which is always ready; write only while idle.
//
// Timing: one shared add/subtract unit does all error arithmetic, one step
// per cycle in the vertical run, and in the horizontal run while the output
// register is free. A pixel is accepted in idle; on the first pixel of a
// line a vertical run then counts its destination rows, and a horizontal
// run emits the copies owed by the horizontal error, each one through the
// output register. The input stalls until the pixel's run is finished. A
// stalled receiver freezes the run on the waiting copy; copies beyond
// MAX_REPLICAS are skipped without waiting. Reset is synchronous and active
// low, restores the register defaults and clears all counters.
`default_nettype none

module nearest_neighbor_line_scaler
    import nnls_pkg::*;
#(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_REPLICAS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Source pixel channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_pix_in              i_in_data,
    // Destination pixel channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_pix_out                  o_out_data,
    // Configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Error width: holds plus and minus MAX_DIM with room for one step.
    localparam int ERR_W = $clog2(MAX_DIM) + 2;

    // Clamp a dimension register to 1 .. MAX_DIM.
    function automatic logic signed [ERR_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (v == '0) begin
            eff_dim = ERR_W'(1);
        end else if (wide > 32'(MAX_DIM)) begin
            eff_dim = ERR_W'(MAX_DIM);
        end else begin
            eff_dim = ERR_W'(wide);
        end
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_src_w, n_src_w;
    logic [CFG_W-1:0] r_src_h, n_src_h;
    logic [CFG_W-1:0] r_dst_w, n_dst_w;
    logic [CFG_W-1:0] r_dst_h, n_dst_h;
    logic             r_text,  n_text;

    // Scaler state
    t_state                   r_state, n_state;
    logic signed [ERR_W-1:0]  r_he, n_he;
    logic signed [ERR_W-1:0]  r_ve, n_ve;
    logic [PIX_W-1:0]         r_prev, n_prev;
    logic [PIX_W-1:0]         r_pp, n_pp;
    logic [COL_W-1:0]         r_col, n_col;
    logic [COL_W-1:0]         r_dest_col, n_dest_col;
    logic [DRB_W-1:0]         r_drb, n_drb;
    logic [ROWS_W-1:0]        r_line_rows, n_line_rows;
    logic [PIX_W-1:0]         r_pix, n_pix;
    logic                     r_first, n_first;
    logic [ROWS_W-1:0]        r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    t_pix_out                 r_out, n_out;

    // Effective dimensions
    logic signed [ERR_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;

    // Shared unit connections
    logic signed [ERR_W-1:0] eu_acc, eu_step, eu_back, eu_next;
    logic                    eu_done, eu_next_nonneg;

    logic        prev_bright;
    logic        swap;
    logic        out_free;
    logic        line_start;
    logic        line_end;
    logic [DRB_W-1:0] drb_sum;

    assign sw_eff = eff_dim(r_src_w);
    assign sh_eff = eff_dim(r_src_h);
    assign dw_eff = eff_dim(r_dst_w);
    assign dh_eff = eff_dim(r_dst_h);

    // The vertical run works on the row error, everything else on the
    // column error.
    assign eu_acc  = (r_state == S_VERT) ? r_ve : r_he;
    assign eu_step = (r_state == S_VERT) ? sh_eff : sw_eff;
    assign eu_back = (r_state == S_VERT) ? dh_eff : dw_eff;

    nnls_err_unit #(
        .W (ERR_W)
    ) u_err (
        .i_acc         (eu_acc),
        .i_step        (eu_step),
        .i_back        (eu_back),
        .o_next        (eu_next),
        .o_done        (eu_done),
        .o_next_nonneg (eu_next_nonneg)
    );

    nnls_luma u_luma (
        .i_pixel  (r_prev),
        .o_bright (prev_bright)
    );

    // The text rule only ever replaces the first copy of a mid-line pixel.
    assign swap = r_text && !r_first && (r_prev != r_pp) && prev_bright;

    // The output register can take a copy when empty or being emptied.
    assign out_free = !r_out_valid || !i_out_stall;

    assign line_start = i_in_data.frame_start || (r_col == '0);
    assign line_end   = (32'(r_col) + 32'd1) >= 32'(sw_eff);
    assign drb_sum    = r_drb + DRB_W'(r_line_rows);

    always_comb begin
        n_src_w     = r_src_w;
        n_src_h     = r_src_h;
        n_dst_w     = r_dst_w;
        n_dst_h     = r_dst_h;
        n_text      = r_text;
        n_state     = r_state;
        n_he        = r_he;
        n_ve        = r_ve;
        n_prev      = r_prev;
        n_pp        = r_pp;
        n_col       = r_col;
        n_dest_col  = r_dest_col;
        n_drb       = r_drb;
        n_line_rows = r_line_rows;
        n_pix       = r_pix;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_SRC_WIDTH:  n_src_w = i_cfg_data;
                CFG_IDX_SRC_HEIGHT: n_src_h = i_cfg_data;
                CFG_IDX_DST_WIDTH:  n_dst_w = i_cfg_data;
                CFG_IDX_DST_HEIGHT: n_dst_h = i_cfg_data;
                CFG_IDX_TEXT_MODE:  n_text  = i_cfg_data[0];
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pix = i_in_data.pixel_in;
                    n_cnt = '0;
                    if (i_in_data.frame_start) begin
                        n_ve  = -dh_eff;
                        n_drb = '0;
                        n_col = '0;
                    end
                    if (line_start) begin
                        n_he        = -dw_eff;
                        n_prev      = '0;
                        n_pp        = '0;
                        n_dest_col  = '0;
                        n_line_rows = '0;
                        n_first     = 1'b1;
                        n_state     = S_VERT;
                    end else begin
                        n_first = 1'b0;
                        n_state = S_HORIZ;
                    end
                end
            end
            S_VERT: begin
                // Count destination rows until the row error turns
                // non-negative, then take off one destination height.
                n_ve = eu_next;
                if (eu_done) begin
                    n_state = S_HORIZ;
                end else if (r_line_rows < ROWS_W'(MAX_REPLICAS)) begin
                    n_line_rows = r_line_rows + ROWS_W'(1);
                end
            end
            S_HORIZ: begin
                if (!eu_done) begin
                    if (r_cnt < ROWS_W'(MAX_REPLICAS)) begin
                        if (out_free) begin
                            n_he        = eu_next;
                            n_cnt       = r_cnt + ROWS_W'(1);
                            n_out_valid = 1'b1;
                            n_out.pixel_out      = ((r_cnt == '0) && swap) ? r_prev : r_pix;
                            n_out.dest_x         = r_dest_col + COL_W'(r_cnt);
                            n_out.first_dest_row = r_drb[COL_W-1:0];
                            n_out.row_count      = r_line_rows;
                            n_out.run_last       = eu_next_nonneg
                                || (r_cnt == ROWS_W'(MAX_REPLICAS - 1));
                        end
                    end else begin
                        // Copies past the cap advance the error silently.
                        n_he = eu_next;
                    end
                end else begin
                    // Run finished: settle the error and the pixel history.
                    n_he       = eu_next;
                    n_dest_col = r_dest_col + COL_W'(r_cnt);
                    if (r_cnt >= ROWS_W'(2)) begin
                        n_pp   = r_pix;
                        n_prev = r_pix;
                    end else if (r_cnt == ROWS_W'(1)) begin
                        n_pp   = r_prev;
                        n_prev = r_pix;
                    end
                    if (line_end) begin
                        n_col = '0;
                        if (32'(drb_sum) >= 32'(dh_eff)) begin
                            n_drb = '0;
                        end else begin
                            n_drb = drb_sum;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= CFG_RST_SRC_WIDTH;
            r_src_h     <= CFG_RST_SRC_HEIGHT;
            r_dst_w     <= CFG_RST_DST_WIDTH;
            r_dst_h     <= CFG_RST_DST_HEIGHT;
            r_text      <= 1'b0;
            r_state     <= S_IDLE;
            r_he        <= -eff_dim(CFG_RST_DST_WIDTH);
            r_ve        <= -eff_dim(CFG_RST_DST_HEIGHT);
            r_prev      <= '0;
            r_pp        <= '0;
            r_col       <= '0;
            r_dest_col  <= '0;
            r_drb       <= '0;
            r_line_rows <= '0;
            r_first     <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_src_w     <= n_src_w;
            r_src_h     <= n_src_h;
            r_dst_w     <= n_dst_w;
            r_dst_h     <= n_dst_h;
            r_text      <= n_text;
            r_state     <= n_state;
            r_he        <= n_he;
            r_ve        <= n_ve;
            r_prev      <= n_prev;
            r_pp        <= n_pp;
            r_col       <= n_col;
            r_dest_col  <= n_dest_col;
            r_drb       <= n_drb;
            r_line_rows <= n_line_rows;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/nnls_checker.sv
// Port-level checker for the nearest-neighbor line scaler, bound to the top.
// Depends on nnls_pkg and on nearest_neighbor_line_scaler.
`default_nettype none

module nnls_checker
    import nnls_pkg::*;
#(
    parameter int MAX_REPLICAS = 64
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_pix_out             o_out_data
);

    // A copy waiting on a stalled receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction changed while stalled");

    // An accepted pixel always keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a pixel was accepted");

    // More copies are owed after a copy that is not the last of its run.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && !i_out_stall && !o_out_data.run_last)
        |=> o_in_stall)
        else $error("pixel released before its last copy");

    // Row count never exceeds the replica cap.
    a_row_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.row_count) <= 32'(MAX_REPLICAS)))
        else $error("row count above the replica cap");

endmodule

bind nearest_neighbor_line_scaler nnls_checker #(
    .MAX_REPLICAS (MAX_REPLICAS)
) u_nnls_checker (.*);

`default_nettype wire
